/* rtl/linear_kalman_filter_step_assert.svh */
// Assertion macros shared by the filter RTL.
// Both expect signals named clk_i and rst_ni in the scope of use.
`ifndef LINEAR_KALMAN_FILTER_STEP_ASSERT_SVH
`define LINEAR_KALMAN_FILTER_STEP_ASSERT_SVH

// Same-cycle implication.
`define LKF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LKF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lkf_pkg.sv */
package lkf_pkg;

  // Default sizes.
  localparam int NStatesDef  = 4;
  localparam int NMeasDef    = 2;
  localparam int NCtrlDef    = 2;
  localparam int FracBitsDef = 16;

  localparam int DataW    = 32;
  localparam int AddrW    = 9;
  localparam int MemDepth = 304;

  // Commands.
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_EST    = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Memory regions of sixteen words, element (r,c) at r*4+c.
  // The first seven match the load selector codes.
  localparam logic [4:0] REG_A   = 5'd0;
  localparam logic [4:0] REG_B   = 5'd1;
  localparam logic [4:0] REG_H   = 5'd2;
  localparam logic [4:0] REG_P   = 5'd3;
  localparam logic [4:0] REG_Q   = 5'd4;
  localparam logic [4:0] REG_R   = 5'd5;
  localparam logic [4:0] REG_X   = 5'd6;
  localparam logic [4:0] REG_XP  = 5'd7;
  localparam logic [4:0] REG_T   = 5'd8;
  localparam logic [4:0] REG_PP  = 5'd9;
  localparam logic [4:0] REG_HP  = 5'd10;
  localparam logic [4:0] REG_S   = 5'd11;
  localparam logic [4:0] REG_SI  = 5'd12;
  localparam logic [4:0] REG_PHT = 5'd13;
  localparam logic [4:0] REG_K   = 5'd14;
  localparam logic [4:0] REG_Y   = 5'd15;
  localparam logic [4:0] REG_W   = 5'd16;
  localparam logic [4:0] REG_ZU  = 5'd17;
  localparam logic [4:0] REG_DET = 5'd18;

  // Load selector codes.
  localparam logic [2:0] SEL_A = 3'd0;
  localparam logic [2:0] SEL_B = 3'd1;
  localparam logic [2:0] SEL_H = 3'd2;
  localparam logic [2:0] SEL_P = 3'd3;
  localparam logic [2:0] SEL_Q = 3'd4;
  localparam logic [2:0] SEL_R = 3'd5;
  localparam logic [2:0] SEL_X = 3'd6;

  // Matrix passes of one estimate.
  localparam logic [3:0] PC_XP   = 4'd0;
  localparam logic [3:0] PC_BU   = 4'd1;
  localparam logic [3:0] PC_T    = 4'd2;
  localparam logic [3:0] PC_PP   = 4'd3;
  localparam logic [3:0] PC_HP   = 4'd4;
  localparam logic [3:0] PC_S    = 4'd5;
  localparam logic [3:0] PC_D1   = 4'd6;
  localparam logic [3:0] PC_D2   = 4'd7;
  localparam logic [3:0] PC_PHT  = 4'd8;
  localparam logic [3:0] PC_K    = 4'd9;
  localparam logic [3:0] PC_Y    = 4'd10;
  localparam logic [3:0] PC_X    = 4'd11;
  localparam logic [3:0] PC_W    = 4'd12;
  localparam logic [3:0] PC_P    = 4'd13;
  localparam logic [3:0] PC_XCPY = 4'd14;
  localparam logic [3:0] PC_PCPY = 4'd15;

  // What happens to the sum once all products are in.
  typedef enum logic [1:0] {
    POST_NONE  = 2'd0,
    POST_ADD_C = 2'd1,
    POST_SUB_C = 2'd2,
    POST_SUB_I = 2'd3
  } post_e;

  // One pass: dst[i][j] = post(sum_m a(i,m) * b(m,j)).
  // a(i,m) = a_r[a_off + i*a_si + m*a_sm], b(m,j) = b_r[b_off + m*b_sm + j*b_sj].
  typedef struct packed {
    logic [4:0] dst_r;
    logic [4:0] a_r;
    logic [3:0] a_off;
    logic [2:0] a_si;
    logic [2:0] a_sm;
    logic [4:0] b_r;
    logic [3:0] b_off;
    logic [2:0] b_sm;
    logic [2:0] b_sj;
    logic [4:0] c_r;
    logic [3:0] c_off;
    logic [2:0] ni;
    logic [2:0] nj;
    logic [2:0] nm;
    logic       init_c;
    post_e      post;
  } pass_t;

  function automatic pass_t pass_desc(input logic [3:0] pc, input logic [2:0] ns,
                                      input logic [2:0] nm, input logic [2:0] nc);
    pass_t d;
    d = '0;
    d.a_si = 3'd4;
    d.a_sm = 3'd1;
    case (pc)
      PC_XP: begin
        d.dst_r = REG_XP; d.a_r = REG_A; d.b_r = REG_X; d.b_sm = 3'd4;
        d.ni = ns; d.nj = 3'd1; d.nm = ns;
      end
      PC_BU: begin
        d.dst_r = REG_XP; d.a_r = REG_B; d.b_r = REG_ZU; d.b_off = 4'd8; d.b_sm = 3'd4;
        d.c_r = REG_XP; d.init_c = 1'b1;
        d.ni = ns; d.nj = 3'd1; d.nm = nc;
      end
      PC_T: begin
        d.dst_r = REG_T; d.a_r = REG_A; d.b_r = REG_P; d.b_sm = 3'd4; d.b_sj = 3'd1;
        d.ni = ns; d.nj = ns; d.nm = ns;
      end
      PC_PP: begin
        d.dst_r = REG_PP; d.a_r = REG_T; d.b_r = REG_A; d.b_sm = 3'd1; d.b_sj = 3'd4;
        d.c_r = REG_Q; d.post = POST_ADD_C;
        d.ni = ns; d.nj = ns; d.nm = ns;
      end
      PC_HP: begin
        d.dst_r = REG_HP; d.a_r = REG_H; d.b_r = REG_PP; d.b_sm = 3'd4; d.b_sj = 3'd1;
        d.ni = nm; d.nj = ns; d.nm = ns;
      end
      PC_S: begin
        d.dst_r = REG_S; d.a_r = REG_HP; d.b_r = REG_H; d.b_sm = 3'd1; d.b_sj = 3'd4;
        d.c_r = REG_R; d.post = POST_ADD_C;
        d.ni = nm; d.nj = nm; d.nm = ns;
      end
      PC_D1: begin
        d.dst_r = REG_DET; d.a_r = REG_S; d.a_si = 3'd0; d.a_sm = 3'd0;
        d.b_r = REG_S; d.b_off = 4'd5;
        d.ni = 3'd1; d.nj = 3'd1; d.nm = 3'd1;
      end
      PC_D2: begin
        d.dst_r = REG_DET; d.a_r = REG_S; d.a_off = 4'd1; d.a_si = 3'd0; d.a_sm = 3'd0;
        d.b_r = REG_S; d.b_off = 4'd4; d.c_r = REG_DET; d.post = POST_SUB_C;
        d.ni = 3'd1; d.nj = 3'd1; d.nm = 3'd1;
      end
      PC_PHT: begin
        d.dst_r = REG_PHT; d.a_r = REG_PP; d.b_r = REG_H; d.b_sm = 3'd1; d.b_sj = 3'd4;
        d.ni = ns; d.nj = nm; d.nm = ns;
      end
      PC_K: begin
        d.dst_r = REG_K; d.a_r = REG_PHT; d.b_r = REG_SI; d.b_sm = 3'd4; d.b_sj = 3'd1;
        d.ni = ns; d.nj = nm; d.nm = nm;
      end
      PC_Y: begin
        d.dst_r = REG_Y; d.a_r = REG_H; d.b_r = REG_XP; d.b_sm = 3'd4;
        d.c_r = REG_ZU; d.post = POST_SUB_C;
        d.ni = nm; d.nj = 3'd1; d.nm = ns;
      end
      PC_X: begin
        d.dst_r = REG_X; d.a_r = REG_K; d.b_r = REG_Y; d.b_sm = 3'd4;
        d.c_r = REG_XP; d.post = POST_ADD_C;
        d.ni = ns; d.nj = 3'd1; d.nm = nm;
      end
      PC_W: begin
        d.dst_r = REG_W; d.a_r = REG_K; d.b_r = REG_H; d.b_sm = 3'd4; d.b_sj = 3'd1;
        d.post = POST_SUB_I;
        d.ni = ns; d.nj = ns; d.nm = nm;
      end
      PC_P: begin
        d.dst_r = REG_P; d.a_r = REG_W; d.b_r = REG_PP; d.b_sm = 3'd4; d.b_sj = 3'd1;
        d.ni = ns; d.nj = ns; d.nm = ns;
      end
      PC_XCPY: begin
        d.dst_r = REG_X; d.c_r = REG_XP; d.post = POST_ADD_C;
        d.ni = ns; d.nj = 3'd1; d.nm = 3'd0;
      end
      PC_PCPY: begin
        d.dst_r = REG_P; d.c_r = REG_PP; d.post = POST_ADD_C;
        d.ni = ns; d.nj = ns; d.nm = 3'd0;
      end
      default: d = '0;
    endcase
    return d;
  endfunction

  // Word index off + x*sx + y*sy inside a region.
  function automatic logic [3:0] word_idx(input logic [3:0] off, input logic [1:0] x,
                                          input logic [2:0] sx, input logic [1:0] y,
                                          input logic [2:0] sy);
    logic [5:0] t;
    t = 6'(off) + 6'(x) * 6'(sx) + 6'(y) * 6'(sy);
    return t[3:0];
  endfunction

  // Saturating arithmetic on 32-bit words.
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = a + b;
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = a - b;
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
    if (a == 32'sh8000_0000) return 32'sh7FFF_FFFF;
    return -a;
  endfunction

endpackage

/* rtl/lkf_if.sv */
// Command channel.
interface lkf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [2:0]         matrix_select;
  logic [1:0]         row_index;
  logic [1:0]         col_index;
  logic signed [31:0] coeff_value;
  logic signed [31:0] meas_0;
  logic signed [31:0] meas_1;
  logic signed [31:0] ctrl_0;
  logic signed [31:0] ctrl_1;

  modport source (
    output valid, command, matrix_select, row_index, col_index, coeff_value,
           meas_0, meas_1, ctrl_0, ctrl_1,
    input  ready
  );
  modport sink (
    input  valid, command, matrix_select, row_index, col_index, coeff_value,
           meas_0, meas_1, ctrl_0, ctrl_1,
    output ready
  );
endinterface

// State result channel.
interface lkf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         element_index;
  logic signed [31:0] state_value;
  logic               last_element;
  logic               ready_flag;
  logic               singular_flag;

  modport source (
    output valid, element_index, state_value, last_element, ready_flag, singular_flag,
    input  ready
  );
  modport sink (
    input  valid, element_index, state_value, last_element, ready_flag, singular_flag,
    output ready
  );
endinterface

/* rtl/lkf_ram.sv */
// Single write port, single registered read port.
module lkf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/linear_kalman_filter_step.sv */
// Channel  Dir   Role    Carries
// in_i     in    sink    command, matrix_select, row/col, coeff_value, meas_0/1, ctrl_0/1
// out_o    out   source  element_index, state_value, last_element, ready/singular flags
//
// Load, commit and no-op commands are handled in the idle state. An estimate uses one
// multiply-accumulate unit fed from two mirrored memories with one read port each, and
// a bit-serial restoring divider for each inverse entry. An estimate before commit
// returns zero-valued results, with the ready flag low, without computing.
// Reset clears the committed flag and the sequencer; memory contents stay undefined.
// A stalled result channel holds the sequencer in its emit step; the last result
// waits in the output register while the next command is taken.
`include "linear_kalman_filter_step_assert.svh"

module linear_kalman_filter_step #(
  parameter int N_STATES  = lkf_pkg::NStatesDef,
  parameter int N_MEAS    = lkf_pkg::NMeasDef,
  parameter int N_CTRL    = lkf_pkg::NCtrlDef,
  parameter int FRAC_BITS = lkf_pkg::FracBitsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  lkf_in_if.sink     in_i,
  lkf_out_if.source  out_o
);

  localparam logic [2:0] NS        = 3'(N_STATES);
  localparam logic [2:0] NM        = 3'(N_MEAS);
  localparam logic [2:0] NC        = 3'(N_CTRL);
  localparam logic [1:0] LastState = 2'(N_STATES - 1);
  localparam logic [1:0] LastInv   = (N_MEAS == 2) ? 2'd3 : 2'd0;
  localparam int         DivW      = 32 + FRAC_BITS;
  localparam int         DivCntW   = $clog2(DivW + 1);
  localparam logic signed [31:0] OneQ = 32'sh1 << FRAC_BITS;
  localparam int         AW        = lkf_pkg::AddrW;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_ZU    = 15'h0002,
    S_ELEM  = 15'h0004,
    S_CCAP  = 15'h0008,
    S_MAC   = 15'h0010,
    S_DRAIN = 15'h0020,
    S_POST  = 15'h0040,
    S_DVRD  = 15'h0080,
    S_DVCAP = 15'h0100,
    S_NRD   = 15'h0200,
    S_NCAP  = 15'h0400,
    S_DIV   = 15'h0800,
    S_DWR   = 15'h1000,
    S_EMRD  = 15'h2000,
    S_EMIT  = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] pc_q, pc_d;
  logic [1:0] i_q, i_d, j_q, j_d, m_q, m_d, k_q, k_d;
  logic       init_q, init_d, sing_q, sing_d, emz_q, emz_d;
  logic       rd_v_q, mul_v_q;

  logic signed [31:0] zu_q [4];
  logic signed [31:0] acc_q, c_q, div_q;
  logic signed [63:0] prod_q;

  logic [DivW-1:0]    dvd_q;
  logic [32:0]        rem_q;
  logic [31:0]        dmag_q;
  logic               dneg_q;
  logic [DivCntW-1:0] dcnt_q;

  logic               out_valid_q, out_last_q, out_ready_q, out_sing_q;
  logic [1:0]         out_idx_q;
  logic signed [31:0] out_val_q;

  logic          we;
  logic [AW-1:0] waddr, raddr0, raddr1;
  logic [31:0]   wdata, rdata0, rdata1;

  lkf_pkg::pass_t desc;
  logic [AW-1:0]  a_addr, b_addr, c_addr, d_addr, emit_addr, div_addr, num_addr;
  logic [3:0]     si_idx;
  logic           in_xfer, out_load, pass_done, emit_last, load_ok;
  logic signed [31:0] post_val, mul_sat, num_val, div_res, op_a, op_b;
  logic signed [63:0] prod_sh;
  logic [31:0]        num_mag;
  logic [32:0]        rem_sh;
  logic               qbit;

  // Two mirrored memories give two operand reads per cycle.
  lkf_ram #(.WIDTH(lkf_pkg::DataW), .DEPTH(lkf_pkg::MemDepth)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr0), .rdata_o(rdata0)
  );
  lkf_ram #(.WIDTH(lkf_pkg::DataW), .DEPTH(lkf_pkg::MemDepth)) u_ram_b (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr1), .rdata_o(rdata1)
  );

  // Address generation for the current pass.
  assign desc = lkf_pkg::pass_desc(pc_q, NS, NM, NC);
  assign a_addr = {desc.a_r, lkf_pkg::word_idx(desc.a_off, i_q, desc.a_si, m_q, desc.a_sm)};
  assign b_addr = {desc.b_r, lkf_pkg::word_idx(desc.b_off, m_q, desc.b_sm, j_q, desc.b_sj)};
  assign c_addr = {desc.c_r, lkf_pkg::word_idx(desc.c_off, i_q, 3'd4, j_q, 3'd1)};
  assign d_addr = {desc.dst_r, lkf_pkg::word_idx(4'd0, i_q, 3'd4, j_q, 3'd1)};
  assign emit_addr = {lkf_pkg::REG_X, i_q, 2'b00};
  assign div_addr  = (N_MEAS == 2) ? {lkf_pkg::REG_DET, 4'd0} : {lkf_pkg::REG_S, 4'd0};

  // Inverse entries: numerator word of S and destination in the inverse.
  always_comb begin
    case (k_q)
      2'd0:    begin num_addr = {lkf_pkg::REG_S, 4'd5}; si_idx = 4'd0; end
      2'd1:    begin num_addr = {lkf_pkg::REG_S, 4'd1}; si_idx = 4'd1; end
      2'd2:    begin num_addr = {lkf_pkg::REG_S, 4'd4}; si_idx = 4'd4; end
      default: begin num_addr = {lkf_pkg::REG_S, 4'd0}; si_idx = 4'd5; end
    endcase
    if (N_MEAS == 1) begin
      num_addr = {lkf_pkg::REG_S, 4'd0};
    end
  end

  assign num_val = (N_MEAS == 1) ? OneQ :
                   ((k_q == 2'd1) || (k_q == 2'd2)) ? lkf_pkg::sat_neg(rdata0) : rdata0;
  assign num_mag = num_val[31] ? 32'(-num_val) : 32'(num_val);

  // Product scaling and the final step of each element.
  assign op_a    = rdata0;
  assign op_b    = rdata1;
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign mul_sat = lkf_pkg::sat64(prod_sh);

  always_comb begin
    case (desc.post)
      lkf_pkg::POST_ADD_C: post_val = lkf_pkg::sat_add(acc_q, c_q);
      lkf_pkg::POST_SUB_C: post_val = lkf_pkg::sat_sub(c_q, acc_q);
      lkf_pkg::POST_SUB_I: post_val = lkf_pkg::sat_sub((i_q == j_q) ? OneQ : 32'sd0, acc_q);
      default:             post_val = acc_q;
    endcase
  end

  // One restoring division step and the saturated quotient.
  assign rem_sh = {rem_q[31:0], dvd_q[DivW-1]};
  assign qbit   = rem_sh >= {1'b0, dmag_q};

  always_comb begin
    if (!dneg_q) begin
      div_res = (|dvd_q[DivW-1:31]) ? 32'sh7FFF_FFFF : dvd_q[31:0];
    end else if ((|dvd_q[DivW-1:32]) || (dvd_q[31] && (|dvd_q[30:0]))) begin
      div_res = 32'sh8000_0000;
    end else begin
      div_res = -$signed(dvd_q[31:0]);
    end
  end

  // Handshakes.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
  assign emit_last  = (i_q == LastState);
  assign pass_done  = ({1'b0, j_q} == desc.nj - 3'd1) && ({1'b0, i_q} == desc.ni - 3'd1);

  // Range check of a load.
  always_comb begin
    case (in_i.matrix_select)
      lkf_pkg::SEL_A, lkf_pkg::SEL_P, lkf_pkg::SEL_Q:
        load_ok = ({1'b0, in_i.row_index} < NS) && ({1'b0, in_i.col_index} < NS);
      lkf_pkg::SEL_B: load_ok = ({1'b0, in_i.row_index} < NS) && ({1'b0, in_i.col_index} < NC);
      lkf_pkg::SEL_H: load_ok = ({1'b0, in_i.row_index} < NM) && ({1'b0, in_i.col_index} < NS);
      lkf_pkg::SEL_R: load_ok = ({1'b0, in_i.row_index} < NM) && ({1'b0, in_i.col_index} < NM);
      lkf_pkg::SEL_X: load_ok = ({1'b0, in_i.row_index} < NS);
      default:        load_ok = 1'b0;
    endcase
  end

  // Memory write port.
  always_comb begin
    we    = 1'b0;
    waddr = d_addr;
    wdata = post_val;
    case (state_q)
      S_IDLE: begin
        we    = in_xfer && (in_i.command == lkf_pkg::CMD_LOAD) && load_ok;
        wdata = in_i.coeff_value;
        if (in_i.matrix_select == lkf_pkg::SEL_X) begin
          waddr = {lkf_pkg::REG_X, in_i.row_index, 2'b00};
        end else begin
          waddr = {2'b00, in_i.matrix_select, in_i.row_index, in_i.col_index};
        end
      end
      S_ZU: begin
        we    = 1'b1;
        waddr = {lkf_pkg::REG_ZU, k_q, 2'b00};
        wdata = zu_q[k_q];
      end
      S_POST: we = 1'b1;
      S_DWR: begin
        we    = 1'b1;
        waddr = {lkf_pkg::REG_SI, si_idx};
        wdata = div_res;
      end
      default: we = 1'b0;
    endcase
  end

  // Read ports.
  always_comb begin
    case (state_q)
      S_ELEM:  raddr0 = c_addr;
      S_MAC:   raddr0 = a_addr;
      S_DVRD:  raddr0 = div_addr;
      S_NRD:   raddr0 = num_addr;
      default: raddr0 = emit_addr;
    endcase
  end
  assign raddr1 = b_addr;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    i_d     = i_q;
    j_d     = j_q;
    m_d     = m_q;
    k_d     = k_q;
    init_d  = init_q;
    sing_d  = sing_q;
    emz_d   = emz_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_i.command)
            lkf_pkg::CMD_COMMIT: init_d = 1'b1;
            lkf_pkg::CMD_EST: begin
              sing_d = 1'b0;
              emz_d  = !init_q;
              i_d    = 2'd0;
              j_d    = 2'd0;
              k_d    = 2'd0;
              pc_d   = lkf_pkg::PC_XP;
              state_d = init_q ? S_ZU : S_EMRD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ZU: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = S_ELEM;
        end
      end
      S_ELEM: begin
        m_d     = 2'd0;
        state_d = S_CCAP;
      end
      S_CCAP: state_d = (desc.nm == 3'd0) ? S_DRAIN : S_MAC;
      S_MAC: begin
        m_d = m_q + 2'd1;
        if ({1'b0, m_q} == desc.nm - 3'd1) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !mul_v_q) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        state_d = S_ELEM;
        if ({1'b0, j_q} == desc.nj - 3'd1) begin
          j_d = 2'd0;
          i_d = i_q + 2'd1;
        end else begin
          j_d = j_q + 2'd1;
        end
        if (pass_done) begin
          i_d = 2'd0;
          case (pc_q)
            lkf_pkg::PC_S: begin
              if (N_MEAS == 2) begin
                pc_d = lkf_pkg::PC_D1;
              end else begin
                state_d = S_DVRD;
              end
            end
            lkf_pkg::PC_D2: state_d = S_DVRD;
            lkf_pkg::PC_P, lkf_pkg::PC_PCPY: state_d = S_EMRD;
            default: pc_d = pc_q + 4'd1;
          endcase
        end
      end
      S_DVRD: state_d = S_DVCAP;
      S_DVCAP: begin
        k_d = 2'd0;
        if (rdata0 == '0) begin
          sing_d  = 1'b1;
          pc_d    = lkf_pkg::PC_XCPY;
          state_d = S_ELEM;
        end else begin
          state_d = S_NRD;
        end
      end
      S_NRD:  state_d = S_NCAP;
      S_NCAP: state_d = S_DIV;
      S_DIV: begin
        if (dcnt_q == DivCntW'(1)) begin
          state_d = S_DWR;
        end
      end
      S_DWR: begin
        if (k_q == LastInv) begin
          pc_d    = lkf_pkg::PC_PHT;
          state_d = S_ELEM;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_NRD;
        end
      end
      S_EMRD: state_d = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          i_d     = i_q + 2'd1;
          state_d = emit_last ? S_IDLE : S_EMRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= lkf_pkg::PC_XP;
      i_q         <= 2'd0;
      j_q         <= 2'd0;
      m_q         <= 2'd0;
      k_q         <= 2'd0;
      init_q      <= 1'b0;
      sing_q      <= 1'b0;
      emz_q       <= 1'b0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      i_q         <= i_d;
      j_q         <= j_d;
      m_q         <= m_d;
      k_q         <= k_d;
      init_q      <= init_d;
      sing_q      <= sing_d;
      emz_q       <= emz_d;
      rd_v_q      <= (state_q == S_MAC);
      mul_v_q     <= rd_v_q;
      out_valid_q <= out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
    end
  end

  // Datapath registers: operands, multiply-accumulate, divider and result slot.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      zu_q[0] <= in_i.meas_0;
      zu_q[1] <= in_i.meas_1;
      zu_q[2] <= in_i.ctrl_0;
      zu_q[3] <= in_i.ctrl_1;
    end
    if (rd_v_q) begin
      prod_q <= op_a * op_b;
    end
    if (state_q == S_CCAP) begin
      c_q   <= rdata0;
      acc_q <= desc.init_c ? rdata0 : 32'sd0;
    end else if (mul_v_q) begin
      acc_q <= lkf_pkg::sat_add(acc_q, mul_sat);
    end
    if (state_q == S_DVCAP) begin
      div_q  <= rdata0;
      dmag_q <= rdata0[31] ? 32'(-$signed(rdata0)) : rdata0;
    end
    if (state_q == S_NCAP) begin
      dvd_q  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      dneg_q <= num_val[31] ^ div_q[31];
      dcnt_q <= DivCntW'(DivW);
    end else if (state_q == S_DIV) begin
      rem_q  <= qbit ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
      dvd_q  <= {dvd_q[DivW-2:0], qbit};
      dcnt_q <= dcnt_q - DivCntW'(1);
    end
    if (out_load) begin
      out_idx_q   <= i_q;
      out_val_q   <= emz_q ? 32'sd0 : $signed(rdata0);
      out_last_q  <= emit_last;
      out_ready_q <= !emz_q;
      out_sing_q  <= !emz_q && sing_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.element_index = out_idx_q;
  assign out_o.state_value   = out_val_q;
  assign out_o.last_element  = out_last_q;
  assign out_o.ready_flag    = out_ready_q;
  assign out_o.singular_flag = out_sing_q;

  // Checks.
  `LKF_ASSERT_IMP(a_post_drained, state_q == S_POST, !rd_v_q && !mul_v_q,
                  "element written back before its products were summed")
  `LKF_ASSERT_IMP(a_div_nonzero, state_q == S_DIV, div_q != 32'sd0,
                  "divider running with a zero divisor")
  `LKF_ASSERT_NXT(a_last_idle, out_load && emit_last, state_q == S_IDLE,
                  "sequencer did not return to idle after the last result")
  `LKF_ASSERT_IMP(a_sing_ready, out_valid_q && out_sing_q, out_ready_q,
                  "singular flag reported on a filter that is not committed")

endmodule
